// ===== sv/lrat_pkg.sv =====
// Package for the lazy range-add / range-max tree core.
// Holds the controller state type, stack control struct, constants and the
// signed max helper. No dependencies.
package lrat_pkg;

  // request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_ADD   = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  // node max after a clear, and the value of an out-of-range query half
  localparam logic [63:0] CLR_MAX      = 64'hC1C1_C1C1_C1C1_C1C1;
  localparam logic [63:0] NEG_SENTINEL = 64'hC87D_2531_6270_0000;

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_NODE,
    ST_EVAL,
    ST_PD_RD_L,
    ST_PD_WR_L,
    ST_PD_WR_R,
    ST_PD_CLR,
    ST_DESCEND,
    ST_RETURN,
    ST_FINISH,
    ST_PU_RD_L,
    ST_PU_RD_R,
    ST_PU_WR,
    ST_DONE
  } state_t;

  // frame stack control
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  // two's complement maximum
  function automatic logic [63:0] smax(input logic [63:0] a, input logic [63:0] b);
    smax = ($signed(a) > $signed(b)) ? a : b;
  endfunction

endpackage

// ===== sv/lazy_range_add_max_tree_core.sv =====
// Top level of the lazy range-add / range-max tree core.
// Uses lrat_pkg, lrat_node_ram and lrat_frame_stack.
//
// Input channel (in_valid/in_stall) carries one request word: req_type,
// lo_index, hi_index, value. A query returns one word on the output channel
// (out_valid/out_stall, max_value); clear, set and add return nothing.
// cfg_we/cfg_wdata write leaf_count; write it only while the core is idle.
//
// The core handles one request at a time; in_stall is low only when idle.
// Each request walks the tree recursively in one node memory with one read
// and one write port and a registered read. Per visited node it reads and
// evaluates the node (RD_NODE, EVAL), pushes a pending tag to the children
// (PD_RD_L, PD_WR_L, PD_WR_R, PD_CLR), picks the next child (DESCEND),
// returns to the parent (RETURN), and rebuilds the node max on the way up
// (set/add: FINISH, PU_RD_L, PU_RD_R, PU_WR; a query passes only FINISH).
// Adds and queries visit up to about four nodes per level. Set, add and
// query are taken in IDLE and end in DONE; clear writes all 4*LEAVES nodes.
//
// After reset the core runs the same clearing pass before
// it accepts a request. Query results sit in an output register; while the
// receiver stalls, the core still accepts the next request and only waits
// when a second query result is ready.
module lazy_range_add_max_tree_core #(
  parameter int LEAVES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [10:0] lo_index,
  input  logic [10:0] hi_index,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] max_value
);

  localparam int NODES = 4 * LEAVES;
  localparam int AW    = $clog2(NODES);
  localparam int LW    = $clog2(LEAVES + 1);
  localparam int IW    = (LW > 12) ? LW : 12;
  localparam int DEPTH = $clog2(LEAVES) + 1;
  localparam int FW    = AW + 2 * IW + 1 + 64;

  lrat_pkg::state_t state, state_next;

  logic [10:0]   leaf_count;
  logic [1:0]    op, op_next;
  logic [IW-1:0] x, x_next, y, y_next;
  logic [63:0]   z, z_next;
  logic [AW-1:0] cur_v, cur_v_next;
  logic [IW-1:0] cur_l, cur_l_next, cur_r, cur_r_next;
  logic [63:0]   acc, acc_next, ret, ret_next;
  logic [63:0]   nmax, nmax_next, tg, tg_next, lmax, lmax_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic          out_valid_next;
  logic [63:0]   max_value_next;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [127:0]  mem_wdata, mem_rdata;
  logic [63:0]   rd_max, rd_tag;

  // stack port
  lrat_pkg::stk_ctrl_t stk_ctrl;
  logic [FW-1:0] stk_push, stk_top;
  logic          stk_empty;
  logic [AW-1:0] fr_v;
  logic [IW-1:0] fr_l, fr_r, fr_m;
  logic          fr_ph;
  logic [63:0]   fr_acc, acc_pop;

  // derived values
  logic [IW-1:0] n_eff, lo_e, hi_e, lo_c, hi_c, cur_m;
  logic [IW:0]   cur_sum, fr_sum;
  logic [AW-1:0] cur_lc, cur_rc, fr_rc;
  logic          covered, range_empty, out_free;

  assign rd_max = mem_rdata[127:64];
  assign rd_tag = mem_rdata[63:0];

  // effective leaf count, saturated to 1..LEAVES
  always_comb begin
    if (leaf_count == 11'd0) begin
      n_eff = IW'(1);
    end else if (IW'(leaf_count) > IW'(LEAVES)) begin
      n_eff = IW'(LEAVES);
    end else begin
      n_eff = IW'(leaf_count);
    end
  end

  assign lo_e = IW'(lo_index);
  assign hi_e = IW'(hi_index);
  assign range_empty = (lo_e > hi_e) || (hi_e == '0) || (lo_e > n_eff);
  assign lo_c = (lo_e == '0) ? IW'(1) : ((lo_e > n_eff) ? n_eff : lo_e);
  assign hi_c = (hi_e > n_eff) ? n_eff : hi_e;

  // split point and children of the current node
  assign cur_sum = {1'b0, cur_l} + {1'b0, cur_r};
  assign cur_m   = cur_sum[IW:1];
  assign cur_lc  = {cur_v[AW-2:0], 1'b0};
  assign cur_rc  = {cur_v[AW-2:0], 1'b1};
  assign covered = (x <= cur_l) && (cur_r <= y);

  // popped frame
  assign {fr_v, fr_l, fr_r, fr_ph, fr_acc} = stk_top;
  assign fr_sum  = {1'b0, fr_l} + {1'b0, fr_r};
  assign fr_m    = fr_sum[IW:1];
  assign fr_rc   = {fr_v[AW-2:0], 1'b1};
  assign acc_pop = (op == lrat_pkg::REQ_QUERY) ? lrat_pkg::smax(fr_acc, ret) : fr_acc;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != lrat_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lrat_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(NODES - 1)) state_next = lrat_pkg::ST_IDLE;
      end
      lrat_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (req_type == lrat_pkg::REQ_CLEAR) begin
            state_next = lrat_pkg::ST_CLEAR;
          end else if (req_type != lrat_pkg::REQ_SET && range_empty) begin
            state_next = lrat_pkg::ST_DONE;
          end else begin
            state_next = lrat_pkg::ST_RD_NODE;
          end
        end
      end
      lrat_pkg::ST_RD_NODE: state_next = lrat_pkg::ST_EVAL;
      lrat_pkg::ST_EVAL: begin
        if (covered) state_next = lrat_pkg::ST_RETURN;
        else if (rd_tag != '0) state_next = lrat_pkg::ST_PD_RD_L;
        else state_next = lrat_pkg::ST_DESCEND;
      end
      lrat_pkg::ST_PD_RD_L: state_next = lrat_pkg::ST_PD_WR_L;
      lrat_pkg::ST_PD_WR_L: state_next = lrat_pkg::ST_PD_WR_R;
      lrat_pkg::ST_PD_WR_R: state_next = lrat_pkg::ST_PD_CLR;
      lrat_pkg::ST_PD_CLR:  state_next = lrat_pkg::ST_DESCEND;
      lrat_pkg::ST_DESCEND: begin
        if (x <= cur_m || y > cur_m) state_next = lrat_pkg::ST_RD_NODE;
        else state_next = lrat_pkg::ST_FINISH;
      end
      lrat_pkg::ST_RETURN: begin
        if (stk_empty) state_next = lrat_pkg::ST_DONE;
        else if (!fr_ph && y > fr_m) state_next = lrat_pkg::ST_RD_NODE;
        else state_next = lrat_pkg::ST_FINISH;
      end
      lrat_pkg::ST_FINISH: begin
        if (op == lrat_pkg::REQ_QUERY) state_next = lrat_pkg::ST_RETURN;
        else state_next = lrat_pkg::ST_PU_RD_L;
      end
      lrat_pkg::ST_PU_RD_L: state_next = lrat_pkg::ST_PU_RD_R;
      lrat_pkg::ST_PU_RD_R: state_next = lrat_pkg::ST_PU_WR;
      lrat_pkg::ST_PU_WR:   state_next = lrat_pkg::ST_RETURN;
      lrat_pkg::ST_DONE: begin
        if (op != lrat_pkg::REQ_QUERY || out_free) state_next = lrat_pkg::ST_IDLE;
      end
      default: state_next = lrat_pkg::ST_IDLE;
    endcase
  end

  // datapath, memory and stack control
  always_comb begin
    op_next        = op;
    x_next         = x;
    y_next         = y;
    z_next         = z;
    cur_v_next     = cur_v;
    cur_l_next     = cur_l;
    cur_r_next     = cur_r;
    acc_next       = acc;
    ret_next       = ret;
    nmax_next      = nmax;
    tg_next        = tg;
    lmax_next      = lmax;
    clr_addr_next  = clr_addr;
    out_valid_next = out_valid && out_stall;
    max_value_next = max_value;
    mem_we         = 1'b0;
    mem_waddr      = cur_v;
    mem_wdata      = {nmax, 64'd0};
    mem_raddr      = cur_v;
    stk_ctrl       = '0;
    stk_push       = {cur_v, cur_l, cur_r, 1'b0, lrat_pkg::NEG_SENTINEL};
    case (state)
      // sweep every node back to its cleared value
      lrat_pkg::ST_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        mem_wdata     = {lrat_pkg::CLR_MAX, 64'd0};
        clr_addr_next = clr_addr + AW'(1);
      end
      // take a request word and start at the root
      lrat_pkg::ST_IDLE: begin
        clr_addr_next = '0;
        op_next       = req_type;
        z_next        = value;
        cur_v_next    = AW'(1);
        cur_l_next    = IW'(1);
        cur_r_next    = n_eff;
        ret_next      = lrat_pkg::NEG_SENTINEL;
        if (req_type == lrat_pkg::REQ_SET) begin
          x_next = lo_c;
          y_next = lo_c;
        end else begin
          x_next = (lo_e == '0) ? IW'(1) : lo_e;
          y_next = hi_c;
        end
      end
      lrat_pkg::ST_RD_NODE: mem_raddr = cur_v;
      // node data is back: finish here or prepare to split
      lrat_pkg::ST_EVAL: begin
        nmax_next = rd_max;
        tg_next   = rd_tag;
        if (covered) begin
          case (op)
            lrat_pkg::REQ_ADD: begin
              mem_we    = 1'b1;
              mem_wdata = {rd_max + z, rd_tag + z};
            end
            lrat_pkg::REQ_SET: begin
              mem_we    = 1'b1;
              mem_wdata = {z, rd_tag};
            end
            default: ret_next = rd_max;
          endcase
        end
      end
      // push the pending tag into both children
      lrat_pkg::ST_PD_RD_L: mem_raddr = cur_lc;
      lrat_pkg::ST_PD_WR_L: begin
        mem_we    = 1'b1;
        mem_waddr = cur_lc;
        mem_wdata = {rd_max + tg, rd_tag + tg};
        mem_raddr = cur_rc;
      end
      lrat_pkg::ST_PD_WR_R: begin
        mem_we    = 1'b1;
        mem_waddr = cur_rc;
        mem_wdata = {rd_max + tg, rd_tag + tg};
      end
      lrat_pkg::ST_PD_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_v;
        mem_wdata = {nmax, 64'd0};
      end
      // go to the first child that meets the range
      lrat_pkg::ST_DESCEND: begin
        acc_next = lrat_pkg::NEG_SENTINEL;
        if (x <= cur_m) begin
          stk_ctrl.push = 1'b1;
          stk_push   = {cur_v, cur_l, cur_r, 1'b0, lrat_pkg::NEG_SENTINEL};
          cur_v_next = cur_lc;
          cur_r_next = cur_m;
        end else if (y > cur_m) begin
          stk_ctrl.push = 1'b1;
          stk_push   = {cur_v, cur_l, cur_r, 1'b1, lrat_pkg::NEG_SENTINEL};
          cur_v_next = cur_rc;
          cur_l_next = cur_m + IW'(1);
        end
      end
      // back in the parent: fold the child result, maybe take the right child
      lrat_pkg::ST_RETURN: begin
        if (!stk_empty) begin
          stk_ctrl.pop = 1'b1;
          cur_v_next   = fr_v;
          cur_l_next   = fr_l;
          cur_r_next   = fr_r;
          acc_next     = acc_pop;
          if (!fr_ph && y > fr_m) begin
            stk_ctrl.push = 1'b1;
            stk_push   = {fr_v, fr_l, fr_r, 1'b1, acc_pop};
            cur_v_next = fr_rc;
            cur_l_next = fr_m + IW'(1);
          end
        end
      end
      lrat_pkg::ST_FINISH: begin
        if (op == lrat_pkg::REQ_QUERY) ret_next = acc;
      end
      // rebuild the node max from its children
      lrat_pkg::ST_PU_RD_L: mem_raddr = cur_lc;
      lrat_pkg::ST_PU_RD_R: begin
        mem_raddr = cur_rc;
        lmax_next = rd_max;
      end
      lrat_pkg::ST_PU_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_v;
        mem_wdata = {lrat_pkg::smax(lmax, rd_max), 64'd0};
      end
      // hand a query result to the output register
      lrat_pkg::ST_DONE: begin
        if (op == lrat_pkg::REQ_QUERY && out_free) begin
          out_valid_next = 1'b1;
          max_value_next = ret;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lrat_pkg::ST_CLEAR;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
      leaf_count <= 11'd1024;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      out_valid <= out_valid_next;
      if (cfg_we) leaf_count <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op        <= op_next;
    x         <= x_next;
    y         <= y_next;
    z         <= z_next;
    cur_v     <= cur_v_next;
    cur_l     <= cur_l_next;
    cur_r     <= cur_r_next;
    acc       <= acc_next;
    ret       <= ret_next;
    nmax      <= nmax_next;
    tg        <= tg_next;
    lmax      <= lmax_next;
    max_value <= max_value_next;
  end

  lrat_node_ram #(
    .AW (AW),
    .DW (128)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lrat_frame_stack #(
    .FW    (FW),
    .DEPTH (DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (stk_ctrl),
    .push_data (stk_push),
    .top_data  (stk_top),
    .empty     (stk_empty)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but core not busy");

  a_walk_write_in_tree: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state != lrat_pkg::ST_CLEAR) |-> ({1'b0, mem_waddr} < (AW + 1)'(4 * n_eff)))
    else $error("node write outside the tree");

  a_result_only_from_done: assert property (@(posedge clk) disable iff (rst)
    (!out_valid ##1 out_valid) |-> ($past(state) == lrat_pkg::ST_DONE))
    else $error("result loaded outside of done state");

endmodule

// ===== sv/lrat_node_ram.sv =====
// Node memory: one word per tree node holding {max, tag}.
// Synchronous write, registered read. Depends on nothing.
module lrat_node_ram #(
  parameter int AW = 12,
  parameter int DW = 128
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lrat_frame_stack.sv =====
// Return stack for the tree walk: saved parent frames.
// A push and a pop in the same cycle replace the top. Uses lrat_pkg.
module lrat_frame_stack #(
  parameter int FW    = 64,
  parameter int DEPTH = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  lrat_pkg::stk_ctrl_t ctrl,
  input  logic [FW-1:0]      push_data,
  output logic [FW-1:0]      top_data,
  output logic               empty
);

  localparam int SPW = $clog2(DEPTH + 1);
  localparam int IXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [FW-1:0]  frames [DEPTH];
  logic [SPW-1:0] sp;
  logic [SPW-1:0] sp_m1;
  logic [IXW-1:0] top_ix;

  assign sp_m1    = sp - SPW'(1);
  assign top_ix   = sp_m1[IXW-1:0];
  assign top_data = frames[top_ix];
  assign empty    = (sp == '0);

  // pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (ctrl.push && !ctrl.pop) begin
      sp <= sp + SPW'(1);
    end else if (ctrl.pop && !ctrl.push) begin
      sp <= sp_m1;
    end
  end

  // frame storage
  always_ff @(posedge clk) begin
    if (ctrl.push && ctrl.pop) begin
      frames[top_ix] <= push_data;
    end else if (ctrl.push) begin
      frames[sp[IXW-1:0]] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (ctrl.push && !ctrl.pop) |-> (sp < SPW'(DEPTH)))
    else $error("frame stack overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> !empty)
    else $error("frame stack underflow");

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for lazy_range_add_max_tree_core: random and directed
// tree requests, an in-bench segment tree predictor, and a result checker.
// Depends on lrat_pkg and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TREE_NODES = 4096;
  localparam int unsigned MAX_LEAVES = 1024;
  localparam int unsigned SETTLE_CYCLES = 5000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] lo;
    logic [10:0] hi;
    logic [63:0] amount;
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [10:0] lo_index = '0;
  logic [10:0] hi_index = '0;
  logic [63:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] max_value;

  request_t    pending_reqs[$];
  logic [63:0] max_expected[$];
  logic [63:0] tree_max[TREE_NODES];
  logic [63:0] tree_tag[TREE_NODES];
  logic [10:0] leaf_cfg = 11'd1024;
  int          err_count = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          calm = 1'b0;

  lazy_range_add_max_tree_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .lo_index(lo_index), .hi_index(hi_index), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .max_value(max_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---- segment tree predictor ----
  function automatic logic [63:0] bigger(logic [63:0] a, logic [63:0] b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

  function automatic void wipe_tree();
    for (int i = 0; i < TREE_NODES; i++) begin
      tree_max[i] = lrat_pkg::CLR_MAX;
      tree_tag[i] = '0;
    end
  endfunction

  function automatic void tag_node(int unsigned v, logic [63:0] w);
    if (v < TREE_NODES) begin
      tree_max[v] += w;
      tree_tag[v] += w;
    end
  endfunction

  function automatic void push_tag(int unsigned v);
    if (v < TREE_NODES && tree_tag[v] != 0) begin
      tag_node(2 * v, tree_tag[v]);
      tag_node(2 * v + 1, tree_tag[v]);
      tree_tag[v] = '0;
    end
  endfunction

  function automatic void refresh_node(int unsigned v);
    if (2 * v + 1 < TREE_NODES) tree_max[v] = bigger(tree_max[2 * v], tree_max[2 * v + 1]);
  endfunction

  function automatic void write_leaf(int unsigned x, logic [63:0] y,
                                     int unsigned l, int unsigned r, int unsigned v);
    int unsigned m;
    if (v >= TREE_NODES) return;
    if (l == r) begin
      tree_max[v] = y;
      return;
    end
    m = (l + r) >> 1;
    push_tag(v);
    if (x <= m) write_leaf(x, y, l, m, 2 * v);
    else write_leaf(x, y, m + 1, r, 2 * v + 1);
    refresh_node(v);
  endfunction

  function automatic void add_span(int unsigned x, int unsigned y, logic [63:0] z,
                                   int unsigned l, int unsigned r, int unsigned v);
    int unsigned m;
    if (v >= TREE_NODES) return;
    if (x <= l && r <= y) begin
      tag_node(v, z);
      return;
    end
    m = (l + r) >> 1;
    push_tag(v);
    if (x <= m) add_span(x, y, z, l, m, 2 * v);
    if (y > m) add_span(x, y, z, m + 1, r, 2 * v + 1);
    refresh_node(v);
  endfunction

  function automatic logic [63:0] span_max(int unsigned x, int unsigned y,
                                           int unsigned l, int unsigned r, int unsigned v);
    int unsigned m;
    logic [63:0] a;
    logic [63:0] b;
    a = lrat_pkg::NEG_SENTINEL;
    b = lrat_pkg::NEG_SENTINEL;
    if (v >= TREE_NODES) return lrat_pkg::NEG_SENTINEL;
    if (x <= l && r <= y) return tree_max[v];
    m = (l + r) >> 1;
    push_tag(v);
    if (x <= m) a = span_max(x, y, l, m, 2 * v);
    if (y > m) b = span_max(x, y, m + 1, r, 2 * v + 1);
    return bigger(a, b);
  endfunction

  function automatic int unsigned live_leaves();
    if (leaf_cfg < 1) return 1;
    if (leaf_cfg > MAX_LEAVES) return MAX_LEAVES;
    return 32'(leaf_cfg);
  endfunction

  // apply one accepted request word to the model, queue a query answer
  function automatic void model_request(request_t rq);
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    bit empty;
    n = live_leaves();
    lo = 32'(rq.lo);
    hi = 32'(rq.hi);
    case (rq.kind)
      lrat_pkg::REQ_CLEAR: wipe_tree();
      lrat_pkg::REQ_SET: begin
        if (lo < 1) lo = 1;
        if (lo > n) lo = n;
        write_leaf(lo, rq.amount, 1, n, 1);
      end
      default: begin
        empty = (lo > hi) || (hi < 1) || (lo > n);
        if (!empty) begin
          if (lo < 1) lo = 1;
          if (hi > n) hi = n;
        end
        if (rq.kind == lrat_pkg::REQ_ADD) begin
          if (!empty) add_span(lo, hi, rq.amount, 1, n, 1);
        end else begin
          max_expected.push_back(empty ? lrat_pkg::NEG_SENTINEL : span_max(lo, hi, 1, n, 1));
        end
      end
    endcase
  endfunction

  // ---- request driver ----
  always @(posedge clk) begin
    request_t rq;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) model_request({req_type, lo_index, hi_index, value});
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        rq = pending_reqs.pop_front();
        req_type <= rq.kind;
        lo_index <= rq.lo;
        hi_index <= rq.hi;
        value <= rq.amount;
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---- result monitor ----
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (max_expected.size() == 0) begin
          $error("max_value word with nothing expected: %h", max_value);
          err_count++;
        end else begin
          want = max_expected.pop_front();
          if (max_value !== want) begin
            $error("max_value expected %h actual %h", want, max_value);
            err_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 8);
      end
    end
  end

  // ---- stimulus ----
  function automatic request_t mk(logic [1:0] k, int lo, int hi, logic [63:0] amt);
    request_t rq;
    rq.kind = k;
    rq.lo = lo[10:0];
    rq.hi = hi[10:0];
    rq.amount = amt;
    return rq;
  endfunction

  function automatic logic [63:0] rand_amount();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return 64'($signed($urandom_range(0, 2000)) - 1000);
      2: return $urandom_range(0, 1) ? 64'h7fff_ffff_ffff_ffff : 64'h8000_0000_0000_0000;
      default: return 64'($urandom_range(0, 1000000));
    endcase
  endfunction

  function automatic request_t rand_request(int unsigned n);
    int unsigned roll;
    int unsigned a;
    int unsigned b;
    logic [1:0] k;
    roll = $urandom_range(0, 99);
    if (roll == 0) k = lrat_pkg::REQ_CLEAR;
    else if (roll < 30) k = lrat_pkg::REQ_SET;
    else if (roll < 60) k = lrat_pkg::REQ_ADD;
    else k = lrat_pkg::REQ_QUERY;
    if ($urandom_range(0, 9) == 0) begin
      // noise: any index pair the fields allow
      a = $urandom_range(0, 2047);
      b = $urandom_range(0, 2047);
    end else begin
      a = $urandom_range(1, n);
      b = $urandom_range(1, n);
      if (a > b) begin
        roll = a;
        a = b;
        b = roll;
      end
    end
    return mk(k, a, b, rand_amount());
  endfunction

  task automatic drain_and_settle();
    do @(negedge clk);
    while (pending_reqs.size() > 0 || in_valid || send_gap > 0 || max_expected.size() > 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_leaf_count(logic [10:0] cnt);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cnt;
    leaf_cfg = cnt;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [10:0] settings[9];
    int unsigned n;
    settings = '{11'd0, 11'd1, 11'd2, 11'd7, 11'd37, 11'd300, 11'd1024, 11'd2047, 11'd5};
    wipe_tree();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed words at the reset leaf count
    pending_reqs.push_back(mk(lrat_pkg::REQ_QUERY, 1, 1024, 0));
    pending_reqs.push_back(mk(lrat_pkg::REQ_QUERY, 3, 9, 0));
    pending_reqs.push_back(mk(lrat_pkg::REQ_SET, 1, 0, 64'h7fff_ffff_ffff_ffff));
    pending_reqs.push_back(mk(lrat_pkg::REQ_SET, 1024, 0, 64'h8000_0000_0000_0000));
    pending_reqs.push_back(mk(lrat_pkg::REQ_SET, 0, 2047, 64'h5555_aaaa_5555_aaaa));
    pending_reqs.push_back(mk(lrat_pkg::REQ_SET, 2047, 0, 64'haaaa_5555_aaaa_5555));
    pending_reqs.push_back(mk(lrat_pkg::REQ_QUERY, 1, 1, 0));
    pending_reqs.push_back(mk(lrat_pkg::REQ_ADD, 1, 1024, 64'd1));
    pending_reqs.push_back(mk(lrat_pkg::REQ_QUERY, 0, 2047, 0));
    pending_reqs.push_back(mk(lrat_pkg::REQ_ADD, 10, 5, 64'd99));
    pending_reqs.push_back(mk(lrat_pkg::REQ_ADD, 0, 0, 64'd77));
    pending_reqs.push_back(mk(lrat_pkg::REQ_ADD, 1500, 2000, 64'd55));
    pending_reqs.push_back(mk(lrat_pkg::REQ_ADD, 900, 2047, 64'hffff_ffff_ffff_ff00));
    pending_reqs.push_back(mk(lrat_pkg::REQ_QUERY, 1000, 1024, 0));
    pending_reqs.push_back(mk(lrat_pkg::REQ_QUERY, 2, 1023, 0));
    pending_reqs.push_back(mk(lrat_pkg::REQ_QUERY, 10, 5, 0));
    pending_reqs.push_back(mk(lrat_pkg::REQ_QUERY, 0, 0, 0));
    pending_reqs.push_back(mk(lrat_pkg::REQ_QUERY, 1100, 1200, 0));
    pending_reqs.push_back(mk(lrat_pkg::REQ_CLEAR, 0, 0, 0));
    pending_reqs.push_back(mk(lrat_pkg::REQ_QUERY, 1, 1024, 0));
    pending_reqs.push_back(mk(lrat_pkg::REQ_QUERY, 1, 1023, 0));
    drain_and_settle();

    // random phases over several tree sizes, the sender fully drained between
    foreach (settings[p]) begin
      write_leaf_count(settings[p]);
      n = live_leaves();
      if (p == 8) calm = 1'b1;
      for (int i = 0; i < 130; i++) pending_reqs.push_back(rand_request(n));
      drain_and_settle();
    end

    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop if the core hangs
  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end
endmodule
